>>> rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types, constants and helpers of the windowed saturation detector
// ----------------------------------------------------------------------------
package wsd_pkg;

   // fixed field widths
   localparam int VALUE_W     = 32;
   localparam int NODE_W      = 2;
   localparam int REG_W       = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int PCT_PROD_W  = VALUE_W + REG_W;

   // defaults for the top level parameters
   localparam int NODES_DEFAULT           = 4;
   localparam int HISTORY_DEPTH_DEFAULT   = 64;
   localparam int BANDWIDTH_KINDS_DEFAULT = 2;

   // register reset values
   localparam logic [REG_W-1:0] WINDOW_LENGTH_RESET     = 7'd5;
   localparam logic [REG_W-1:0] BANDWIDTH_PERCENT_RESET = 7'd80;
   localparam logic [REG_W-1:0] CAPACITY_PERCENT_RESET  = 7'd80;

   // averages are compared in percent, so sums are scaled by this
   localparam int PERCENT_SCALE = 100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LENGTH     = 2'd0,
      CSR_BANDWIDTH_PERCENT = 2'd1,
      CSR_CAPACITY_PERCENT  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_START,
      ST_WAIT,
      ST_EMIT
   } walk_state_type;

   typedef struct packed {
      logic [REG_W-1:0] window_length;
      logic [REG_W-1:0] bandwidth_percent;
      logic [REG_W-1:0] capacity_percent;
   } cfg_type;

   typedef struct packed {
      logic [NODE_W-1:0]  node;
      logic [VALUE_W-1:0] bandwidth_a;
      logic [VALUE_W-1:0] bandwidth_b;
      logic [VALUE_W-1:0] capacity_used;
      logic [VALUE_W-1:0] ceiling_bandwidth_a;
      logic [VALUE_W-1:0] ceiling_bandwidth_b;
      logic [VALUE_W-1:0] ceiling_capacity;
   } req_payload_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_out;
      logic              bandwidth_saturated;
      logic              capacity_saturated;
   } rsp_payload_type;

   // bits needed to index n entries, at least one
   function automatic int index_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

>>> rtl/core/wsd_channels.sv
// ----------------------------------------------------------------------------
// wsd channels
// valid/ready channels carrying sample words in and flag words out
// ----------------------------------------------------------------------------
interface wsd_req_if;
   logic                     valid;
   logic                     ready;
   wsd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wsd_rsp_if;
   logic                     valid;
   logic                     ready;
   wsd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/windowed_saturation_detector.sv
// ----------------------------------------------------------------------------
// windowed_saturation_detector
// per-node moving window saturation flags for bandwidth and capacity
// ----------------------------------------------------------------------------
// usage
//   req_ch carries one sample word per monitoring interval: node index, two
//   bandwidth readings, capacity in use and the node's ceilings. rsp_ch
//   returns one flag word per sample, in order, with the node echoed.
//   csr_we/csr_index/csr_data write window_length, bandwidth_percent and
//   capacity_percent; write them only while no word is in flight.
// operation
//   one sample word is worked on at a time. after acceptance the walker
//   reads the older entries of the clamped window from the history memory,
//   sums them and passes the sums to the threshold unit; the time per word
//   is set by the single read port of the history memory, walked one entry
//   per cycle, plus a three stage multiply/compare.
// reset
//   synchronous, active high; clears heads, fill counts and registers. the
//   history memory is not cleared: entries beyond a node's fill count read
//   as zero, so no clearing pass is needed.
// stalls
//   a finished flag word sits in the output register while rsp ready is low;
//   the next sample word is still taken and worked on, and holds before the
//   output register until it is free.
// ----------------------------------------------------------------------------
module windowed_saturation_detector #(
   parameter int NODES           = wsd_pkg::NODES_DEFAULT,
   parameter int HISTORY_DEPTH   = wsd_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int BANDWIDTH_KINDS = wsd_pkg::BANDWIDTH_KINDS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   wsd_req_if.sink                           req_ch,
   wsd_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [wsd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wsd_pkg::REG_W-1:0]         csr_data
);
   import wsd_pkg::*;

   localparam int LANES  = BANDWIDTH_KINDS + 1;
   localparam int DEPTH  = NODES * HISTORY_DEPTH;
   localparam int ADDR_W = index_width(DEPTH);
   localparam int WIN_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = VALUE_W + WIN_W;
   localparam int WORD_W = LANES * VALUE_W;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // memory port wires
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;

   // threshold unit wires
   logic                                  thr_start, thr_done, thr_bw_sat, thr_cap_sat;
   logic [BANDWIDTH_KINDS:0][SUM_W-1:0]   thr_sums;
   logic [BANDWIDTH_KINDS:0][VALUE_W-1:0] thr_ceilings;
   logic [REG_W-1:0]                      thr_bw_pct, thr_cap_pct;
   logic [WIN_W-1:0]                      thr_window;

   // result handoff into the output register
   logic            emit_valid, emit_ready;
   rsp_payload_type emit_word;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_word_ff;

   // register writes, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH:     cfg_in.window_length     = csr_data;
            CSR_BANDWIDTH_PERCENT: cfg_in.bandwidth_percent = csr_data;
            CSR_CAPACITY_PERCENT:  cfg_in.capacity_percent  = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length     <= WINDOW_LENGTH_RESET;
         cfg_ff.bandwidth_percent <= BANDWIDTH_PERCENT_RESET;
         cfg_ff.capacity_percent  <= CAPACITY_PERCENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sample intake, history write and window walk
   wsd_walker #(
      .NODES           (NODES),
      .HISTORY_DEPTH   (HISTORY_DEPTH),
      .BANDWIDTH_KINDS (BANDWIDTH_KINDS)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .cfg          (cfg_ff),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .thr_start    (thr_start),
      .thr_sums     (thr_sums),
      .thr_ceilings (thr_ceilings),
      .thr_bw_pct   (thr_bw_pct),
      .thr_cap_pct  (thr_cap_pct),
      .thr_window   (thr_window),
      .thr_done     (thr_done),
      .thr_bw_sat   (thr_bw_sat),
      .thr_cap_sat  (thr_cap_sat),
      .emit_valid   (emit_valid),
      .emit_ready   (emit_ready),
      .emit_word    (emit_word)
   );

   // history of every node, lane 0 capacity, lanes above bandwidth kinds
   wsd_history_mem #(
      .DEPTH  (DEPTH),
      .WORD_W (WORD_W)
   ) u_history (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // exact integer compare of the window averages
   wsd_threshold #(
      .HISTORY_DEPTH   (HISTORY_DEPTH),
      .BANDWIDTH_KINDS (BANDWIDTH_KINDS)
   ) u_threshold (
      .clock               (clock),
      .reset               (reset),
      .start               (thr_start),
      .sums                (thr_sums),
      .ceilings            (thr_ceilings),
      .bandwidth_percent   (thr_bw_pct),
      .capacity_percent    (thr_cap_pct),
      .window              (thr_window),
      .done                (thr_done),
      .bandwidth_saturated (thr_bw_sat),
      .capacity_saturated  (thr_cap_sat)
   );

   // output register: free when empty or being drained this cycle
   assign emit_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_valid && emit_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid && emit_ready) begin
         rsp_word_ff <= emit_word;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_word_ff;

endmodule

>>> rtl/core/wsd_history_mem.sv
// ----------------------------------------------------------------------------
// wsd_history_mem
// sample history of all nodes, one write port, one registered read port
// ----------------------------------------------------------------------------
module wsd_history_mem #(
   parameter int DEPTH  = 256,
   parameter int WORD_W = 96,
   localparam int ADDR_W = wsd_pkg::index_width(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WORD_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WORD_W-1:0] rdata
);
   import wsd_pkg::*;

   logic [WORD_W-1:0] mem_array [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_array[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_array[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/wsd_threshold.sv
// ----------------------------------------------------------------------------
// wsd_threshold
// three stage compare of sum*100 against ceiling*percent*window per lane
// ----------------------------------------------------------------------------
module wsd_threshold #(
   parameter int HISTORY_DEPTH   = 64,
   parameter int BANDWIDTH_KINDS = 2,
   localparam int WIN_W  = $clog2(HISTORY_DEPTH + 1),
   localparam int SUM_W  = wsd_pkg::VALUE_W + WIN_W,
   localparam int PROD_W = wsd_pkg::PCT_PROD_W + WIN_W
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [BANDWIDTH_KINDS:0][SUM_W-1:0]            sums,
   input  logic [BANDWIDTH_KINDS:0][wsd_pkg::VALUE_W-1:0] ceilings,
   input  logic [wsd_pkg::REG_W-1:0]                      bandwidth_percent,
   input  logic [wsd_pkg::REG_W-1:0]                      capacity_percent,
   input  logic [WIN_W-1:0]                               window,
   output logic                                           done,
   output logic                                           bandwidth_saturated,
   output logic                                           capacity_saturated
);
   import wsd_pkg::*;

   // lane 0 is capacity, lanes 1 and up are bandwidth kinds
   logic [BANDWIDTH_KINDS:0][REG_W-1:0]      pct;
   logic [BANDWIDTH_KINDS:0][PROD_W-1:0]     lhs1_ff, lhs1_in, lhs2_ff, rhs2_ff, rhs2_in;
   logic [BANDWIDTH_KINDS:0][PCT_PROD_W-1:0] cp1_ff, cp1_in;
   logic [BANDWIDTH_KINDS:0]                 over;
   logic s1_valid_ff, s2_valid_ff, done_ff;
   logic bw_sat_ff, bw_sat_in, cap_sat_ff, cap_sat_in;

   always_comb begin
      for (int l = 0; l <= BANDWIDTH_KINDS; l++) begin
         pct[l]     = (l == 0) ? capacity_percent : bandwidth_percent;
         lhs1_in[l] = PROD_W'(sums[l]) * PROD_W'(PERCENT_SCALE);
         cp1_in[l]  = PCT_PROD_W'(ceilings[l]) * PCT_PROD_W'(pct[l]);
         rhs2_in[l] = PROD_W'(cp1_ff[l]) * PROD_W'(window);
         over[l]    = lhs2_ff[l] > rhs2_ff[l];
      end
      cap_sat_in = over[0];
      bw_sat_in  = |over[BANDWIDTH_KINDS:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      lhs1_ff    <= lhs1_in;
      cp1_ff     <= cp1_in;
      lhs2_ff    <= lhs1_ff;
      rhs2_ff    <= rhs2_in;
      bw_sat_ff  <= bw_sat_in;
      cap_sat_ff <= cap_sat_in;
   end

   assign done                = done_ff;
   assign bandwidth_saturated = bw_sat_ff;
   assign capacity_saturated  = cap_sat_ff;

endmodule

>>> rtl/core/wsd_walker.sv
// ----------------------------------------------------------------------------
// wsd_walker
// takes a sample, writes it to the history and walks the window back
// ----------------------------------------------------------------------------
module wsd_walker #(
   parameter int NODES           = 4,
   parameter int HISTORY_DEPTH   = 64,
   parameter int BANDWIDTH_KINDS = 2,
   localparam int LANES  = BANDWIDTH_KINDS + 1,
   localparam int IDX_W  = wsd_pkg::index_width(HISTORY_DEPTH),
   localparam int NIDX_W = wsd_pkg::index_width(NODES),
   localparam int ADDR_W = wsd_pkg::index_width(NODES * HISTORY_DEPTH),
   localparam int WIN_W  = $clog2(HISTORY_DEPTH + 1),
   localparam int SUM_W  = wsd_pkg::VALUE_W + WIN_W,
   localparam int WORD_W = LANES * wsd_pkg::VALUE_W
) (
   input  logic                                           clock,
   input  logic                                           reset,
   wsd_req_if.sink                                        req_ch,
   input  wsd_pkg::cfg_type                               cfg,
   output logic                                           mem_we,
   output logic [ADDR_W-1:0]                              mem_waddr,
   output logic [WORD_W-1:0]                              mem_wdata,
   output logic                                           mem_re,
   output logic [ADDR_W-1:0]                              mem_raddr,
   input  logic [WORD_W-1:0]                              mem_rdata,
   output logic                                           thr_start,
   output logic [BANDWIDTH_KINDS:0][SUM_W-1:0]            thr_sums,
   output logic [BANDWIDTH_KINDS:0][wsd_pkg::VALUE_W-1:0] thr_ceilings,
   output logic [wsd_pkg::REG_W-1:0]                      thr_bw_pct,
   output logic [wsd_pkg::REG_W-1:0]                      thr_cap_pct,
   output logic [WIN_W-1:0]                               thr_window,
   input  logic                                           thr_done,
   input  logic                                           thr_bw_sat,
   input  logic                                           thr_cap_sat,
   output logic                                           emit_valid,
   input  logic                                           emit_ready,
   output wsd_pkg::rsp_payload_type                       emit_word
);
   import wsd_pkg::*;

   typedef logic [BANDWIDTH_KINDS:0][VALUE_W-1:0] lane_val_type;
   typedef logic [BANDWIDTH_KINDS:0][SUM_W-1:0]   lane_sum_type;

   walk_state_type     state_ff, state_in;
   logic               accept, in_range;
   logic [NIDX_W-1:0]  nix;
   logic [IDX_W-1:0]   head_ff [NODES];
   logic [WIN_W-1:0]   fill_ff [NODES];
   logic [IDX_W-1:0]   head_cur, head_next, rd_idx_ff, rd_idx_in;
   logic [WIN_W-1:0]   fill_cur, fill_next, fill_cur_ff, fill_cur_in;
   logic [WIN_W-1:0]   win_eff, win_ff, win_in, remain_ff, remain_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [REG_W-1:0]   bw_pct_ff, bw_pct_in, cap_pct_ff, cap_pct_in;
   lane_val_type       sample, ceil_ff, ceil_in, rd_lanes;
   lane_sum_type       sum_ff, sum_in;
   logic               rd_pend_ff, rd_pend_in, rd_ok_ff, rd_ok_in;
   logic               bw_sat_ff, bw_sat_in, cap_sat_ff, cap_sat_in;

   assign accept   = req_ch.valid && req_ch.ready;
   assign in_range = 32'(req_ch.payload.node) < 32'(NODES);
   assign nix      = NIDX_W'(req_ch.payload.node);
   assign head_cur = head_ff[nix];
   assign fill_cur = fill_ff[nix];
   assign rd_lanes = mem_rdata;

   // window register clamped to 1..HISTORY_DEPTH
   always_comb begin
      if (32'(cfg.window_length) > 32'(HISTORY_DEPTH)) begin
         win_eff = WIN_W'(HISTORY_DEPTH);
      end else if (cfg.window_length == '0) begin
         win_eff = WIN_W'(1);
      end else begin
         win_eff = WIN_W'(cfg.window_length);
      end
   end

   always_comb begin
      sample    = '0;
      sample[0] = req_ch.payload.capacity_used;
      sample[1] = req_ch.payload.bandwidth_a;
      ceil_in   = '0;
      ceil_in[0] = req_ch.payload.ceiling_capacity;
      ceil_in[1] = req_ch.payload.ceiling_bandwidth_a;
      if (BANDWIDTH_KINDS > 1) begin
         sample[BANDWIDTH_KINDS]  = req_ch.payload.bandwidth_b;
         ceil_in[BANDWIDTH_KINDS] = req_ch.payload.ceiling_bandwidth_b;
      end
   end

   assign head_next = (32'(head_cur) == HISTORY_DEPTH - 1) ? '0 : head_cur + IDX_W'(1);
   assign fill_next = (fill_cur == WIN_W'(HISTORY_DEPTH)) ? fill_cur : fill_cur + WIN_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!in_range) begin
                  state_in = ST_EMIT;
               end else if (win_eff == WIN_W'(1)) begin
                  state_in = ST_START;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (remain_ff == WIN_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_START;
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (thr_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      mem_re       = (state_ff == ST_WALK);
      thr_start    = (state_ff == ST_START);
      emit_valid   = (state_ff == ST_EMIT);
   end

   // datapath
   always_comb begin
      node_in     = node_ff;
      win_in      = win_ff;
      bw_pct_in   = bw_pct_ff;
      cap_pct_in  = cap_pct_ff;
      fill_cur_in = fill_cur_ff;
      rd_idx_in   = rd_idx_ff;
      remain_in   = remain_ff;
      sum_in      = sum_ff;
      bw_sat_in   = bw_sat_ff;
      cap_sat_in  = cap_sat_ff;
      rd_pend_in  = 1'b0;
      rd_ok_in    = 1'b0;
      mem_we      = accept && in_range;
      mem_waddr   = ADDR_W'(nix) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(head_cur);
      mem_wdata   = sample;
      mem_raddr   = ADDR_W'(NIDX_W'(node_ff)) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(rd_idx_ff);
      if (accept) begin
         node_in     = req_ch.payload.node;
         win_in      = win_eff;
         bw_pct_in   = cfg.bandwidth_percent;
         cap_pct_in  = cfg.capacity_percent;
         fill_cur_in = fill_next;
         rd_idx_in   = (head_cur == '0) ? IDX_W'(HISTORY_DEPTH - 1) : head_cur - IDX_W'(1);
         remain_in   = win_eff - WIN_W'(1);
         bw_sat_in   = 1'b0;
         cap_sat_in  = 1'b0;
         // newest entry comes straight from the word, no read needed
         for (int l = 0; l <= BANDWIDTH_KINDS; l++) begin
            sum_in[l] = SUM_W'(sample[l]);
         end
      end else begin
         if (rd_pend_ff && rd_ok_ff) begin
            for (int l = 0; l <= BANDWIDTH_KINDS; l++) begin
               sum_in[l] = sum_ff[l] + SUM_W'(rd_lanes[l]);
            end
         end
         if (state_ff == ST_WALK) begin
            rd_pend_in = 1'b1;
            // entries past the fill count were never written and count as zero
            rd_ok_in   = WIN_W'(rd_idx_ff) < fill_cur_ff;
            rd_idx_in  = (rd_idx_ff == '0) ? IDX_W'(HISTORY_DEPTH - 1)
                                           : rd_idx_ff - IDX_W'(1);
            remain_in  = remain_ff - WIN_W'(1);
         end
         if (state_ff == ST_WAIT && thr_done) begin
            bw_sat_in  = thr_bw_sat;
            cap_sat_in = thr_cap_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         for (int n = 0; n < NODES; n++) begin
            head_ff[n] <= '0;
            fill_ff[n] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         if (accept && in_range) begin
            head_ff[nix] <= head_next;
            fill_ff[nix] <= fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      win_ff      <= win_in;
      bw_pct_ff   <= bw_pct_in;
      cap_pct_ff  <= cap_pct_in;
      fill_cur_ff <= fill_cur_in;
      rd_idx_ff   <= rd_idx_in;
      remain_ff   <= remain_in;
      sum_ff      <= sum_in;
      ceil_ff     <= accept ? ceil_in : ceil_ff;
      rd_ok_ff    <= rd_ok_in;
      bw_sat_ff   <= bw_sat_in;
      cap_sat_ff  <= cap_sat_in;
   end

   assign thr_sums     = sum_ff;
   assign thr_ceilings = ceil_ff;
   assign thr_bw_pct   = bw_pct_ff;
   assign thr_cap_pct  = cap_pct_ff;
   assign thr_window   = win_ff;

   assign emit_word.node_out            = node_ff;
   assign emit_word.bandwidth_saturated = bw_sat_ff;
   assign emit_word.capacity_saturated  = cap_sat_ff;

endmodule

>>> rtl/core/wsd_checker.sv
// ----------------------------------------------------------------------------
// wsd_checker
// port level checks of the windowed saturation detector, bound to the top
// ----------------------------------------------------------------------------
module wsd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [wsd_pkg::NODE_W-1:0] rsp_node_out
);
   import wsd_pkg::*;

   // words taken in and not yet delivered
   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_fire && !rsp_fire) begin
         outstanding_in = outstanding_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         outstanding_in = outstanding_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // output register empties on reset
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // one word at a time: no intake right after an intake
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("word taken in back to back");

   // no result without a word behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("result without accepted word");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_node_out))
      else $error("stalled result changed");

endmodule

bind windowed_saturation_detector wsd_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_node_out (rsp_ch.payload.node_out)
);

>>> verif/windowed_saturation_detector_tb.sv
// ----------------------------------------------------------------------------
// windowed_saturation_detector_tb
// self-checking bench for the windowed saturation detector: a directed table
// of samples and register writes, then random phases with changing window
// and percent settings, idling on both channels and a long output hold-off.
// every flag word is held to typed flags or a local per-node history predictor
// ----------------------------------------------------------------------------
module windowed_saturation_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wsd_pkg::*;

   localparam int NODE_COUNT = NODES_DEFAULT;
   localparam int DEPTH      = HISTORY_DEPTH_DEFAULT;
   localparam logic [VALUE_W-1:0] MAX32 = '1;

   // pacing and run length
   localparam int SENDER_IDLE_PCT    = 46;
   localparam int RECEIVER_STALL_PCT = 46;
   localparam int BOTH_IDLE_PCT      = 7;
   localparam int PHASES             = 12;
   localparam int PHASE_WORDS        = 125;
   localparam int HOLD_CYCLES        = 600;
   // far longer than the worst case word, so a quiet span this long is a hang
   localparam int QUIET_LIMIT        = 5000;
   localparam int SETTLE_CYCLES      = 80;

   typedef enum {ROW_WORD, ROW_REG} row_kind_type;
   typedef enum {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;

   typedef struct {
      row_kind_type               kind;
      csr_index_type              reg_index;
      logic [REG_W-1:0]           reg_value;
      req_payload_type            word;
      bit                         typed;
      rsp_payload_type            flags;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [REG_W-1:0]       csr_data;

   wsd_req_if req_ch ();
   wsd_rsp_if rsp_ch ();

   windowed_saturation_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state: per-node sample history, write slot and register copies
   logic [VALUE_W-1:0] history_bw_a [NODE_COUNT][DEPTH];
   logic [VALUE_W-1:0] history_bw_b [NODE_COUNT][DEPTH];
   logic [VALUE_W-1:0] history_cap  [NODE_COUNT][DEPTH];
   int                 next_slot    [NODE_COUNT];
   logic [REG_W-1:0]   window_reg;
   logic [REG_W-1:0]   bw_percent_reg;
   logic [REG_W-1:0]   cap_percent_reg;

   // flag words still owed by the block, oldest first
   rsp_payload_type expected_flags [$];

   // directed stimulus table
   stim_row_type directed [$];

   // per-node ceilings held for a whole random phase
   logic [VALUE_W-1:0] node_ceil_a   [NODE_COUNT];
   logic [VALUE_W-1:0] node_ceil_b   [NODE_COUNT];
   logic [VALUE_W-1:0] node_ceil_cap [NODE_COUNT];

   int errors        = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_served  = 0;

   // strict compare of the window average against ceiling * percent / 100,
   // cross-multiplied so no division is needed
   function automatic bit exceeds_limit(input logic [63:0] sum,
                                        input logic [VALUE_W-1:0] ceiling,
                                        input logic [REG_W-1:0] percent,
                                        input int win);
      logic [63:0] scaled_sum;
      logic [63:0] scaled_ceiling;
      scaled_sum     = sum * 64'(PERCENT_SCALE);
      scaled_ceiling = 64'(ceiling) * 64'(percent) * 64'(win);
      return scaled_sum > scaled_ceiling;
   endfunction

   // stores the sample, sums the newest window entries of its node and
   // advances that node's slot; a 2-bit node is always in range here
   function automatic rsp_payload_type predict_flags(input req_payload_type word);
      int              win;
      int              slot;
      int              idx;
      logic [63:0]     sum_a;
      logic [63:0]     sum_b;
      logic [63:0]     sum_cap;
      rsp_payload_type flags;
      win = int'(window_reg);
      if (win == 0) begin
         win = 1;
      end
      if (win > DEPTH) begin
         win = DEPTH;
      end
      slot = next_slot[word.node];
      history_bw_a[word.node][slot] = word.bandwidth_a;
      history_bw_b[word.node][slot] = word.bandwidth_b;
      history_cap[word.node][slot]  = word.capacity_used;
      sum_a   = '0;
      sum_b   = '0;
      sum_cap = '0;
      for (int i = 0; i < win; i++) begin
         idx = (slot + DEPTH - i) % DEPTH;
         sum_a   += 64'(history_bw_a[word.node][idx]);
         sum_b   += 64'(history_bw_b[word.node][idx]);
         sum_cap += 64'(history_cap[word.node][idx]);
      end
      next_slot[word.node] = (slot + 1) % DEPTH;
      flags.node_out = word.node;
      flags.bandwidth_saturated =
         exceeds_limit(sum_a, word.ceiling_bandwidth_a, bw_percent_reg, win) ||
         exceeds_limit(sum_b, word.ceiling_bandwidth_b, bw_percent_reg, win);
      flags.capacity_saturated =
         exceeds_limit(sum_cap, word.ceiling_capacity, cap_percent_reg, win);
      return flags;
   endfunction

   function automatic stim_row_type word_row(input logic [NODE_W-1:0] node,
                                             input logic [VALUE_W-1:0] bw_a, bw_b, cap,
                                             input logic [VALUE_W-1:0] ceil_a, ceil_b,
                                             input logic [VALUE_W-1:0] ceil_cap,
                                             input bit typed = 1'b0,
                                             input bit bw_flag = 1'b0,
                                             input bit cap_flag = 1'b0);
      stim_row_type row;
      row.kind      = ROW_WORD;
      row.reg_index = CSR_WINDOW_LENGTH;
      row.reg_value = '0;
      row.word      = '{node, bw_a, bw_b, cap, ceil_a, ceil_b, ceil_cap};
      row.typed     = typed;
      row.flags     = '{node, bw_flag, cap_flag};
      return row;
   endfunction

   function automatic stim_row_type reg_row(input csr_index_type index,
                                            input logic [REG_W-1:0] value);
      stim_row_type row;
      row.kind      = ROW_REG;
      row.reg_index = index;
      row.reg_value = value;
      row.word      = '0;
      row.typed     = 1'b0;
      row.flags     = '0;
      return row;
   endfunction

   // appends one row to the directed table
   function automatic void add_row(input stim_row_type row);
      directed = {directed, row};
   endfunction

   // reading scattered around ceiling * percent / 100, so flags toggle
   function automatic logic [VALUE_W-1:0] near_limit(input logic [VALUE_W-1:0] ceiling,
                                                     input logic [REG_W-1:0] percent);
      logic [63:0] target;
      target = (64'(ceiling) * 64'(percent)) / 64'(PERCENT_SCALE);
      target = (target * 64'($urandom_range(140, 60))) / 64'd100;
      if (target > 64'(MAX32)) begin
         target = 64'(MAX32);
      end
      return target[VALUE_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] pick_extreme();
      case ($urandom_range(2))
         0: return '0;
         1: return MAX32;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [REG_W-1:0] pick_percent(input int sel);
      case (sel % 5)
         0: return 7'd100;
         1: return 7'd0;
         2: return 7'd127;
         3: return REG_W'($urandom_range(99, 1));
         default: return 7'd80;
      endcase
   endfunction

   // register write; called at a falling edge, returns at a falling edge
   task automatic write_reg(input csr_index_type index, input logic [REG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      case (index)
         CSR_WINDOW_LENGTH:     window_reg      = value;
         CSR_BANDWIDTH_PERCENT: bw_percent_reg  = value;
         CSR_CAPACITY_PERCENT:  cap_percent_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // offer one sample word and hold it until accepted, then queue its flags
   task automatic offer_word(input req_payload_type word, input bit typed,
                             input rsp_payload_type typed_flags);
      rsp_payload_type flags;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= word;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      flags = predict_flags(word);
      expected_flags = {expected_flags, (typed ? typed_flags : flags)};
      @(negedge clock);
   endtask

   // stop offering and wait for every owed flag word
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (expected_flags.size() != 0);
   endtask

   // output side: random stalls, or a long counted hold-off when requested
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_served++;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // compare each accepted flag word with the oldest owed one
   always @(posedge clock) begin : check_flags
      rsp_payload_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_flags.size() == 0) begin
            $error("flag word for node %0d with nothing owed", rsp_ch.payload.node_out);
            errors++;
         end else begin
            want = expected_flags.pop_front();
            if (rsp_ch.payload.node_out !== want.node_out) begin
               $error("node_out: expected %0d, got %0d",
                      want.node_out, rsp_ch.payload.node_out);
               errors++;
            end
            if (rsp_ch.payload.bandwidth_saturated !== want.bandwidth_saturated) begin
               $error("bandwidth_saturated: expected %0b, got %0b",
                      want.bandwidth_saturated, rsp_ch.payload.bandwidth_saturated);
               errors++;
            end
            if (rsp_ch.payload.capacity_saturated !== want.capacity_saturated) begin
               $error("capacity_saturated: expected %0b, got %0b",
                      want.capacity_saturated, rsp_ch.payload.capacity_saturated);
               errors++;
            end
         end
      end
   end

   // watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      req_payload_type sample;
      pace_type        pace;
      bit              hold_phase;
      int              mix;
      logic [NODE_W-1:0] last_node;

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_WINDOW_LENGTH;
      csr_data       = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;

      // predictor starts from the reset state: empty history, default registers
      for (int n = 0; n < NODE_COUNT; n++) begin
         next_slot[n] = 0;
         for (int s = 0; s < DEPTH; s++) begin
            history_bw_a[n][s] = '0;
            history_bw_b[n][s] = '0;
            history_cap[n][s]  = '0;
         end
      end
      window_reg      = WINDOW_LENGTH_RESET;
      bw_percent_reg  = BANDWIDTH_PERCENT_RESET;
      cap_percent_reg = CAPACITY_PERCENT_RESET;
      last_node       = '0;

      // directed table, registers at reset values until the first write
      // all zero: empty history never flags
      add_row(word_row(2'd0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0, 1'b0));
      // zero ceilings: any nonzero sum flags
      add_row(word_row(2'd1, MAX32, MAX32, MAX32, '0, '0, '0, 1'b1, 1'b1, 1'b1));
      // one full-scale sample among unfilled slots stays under 80 percent
      add_row(word_row(2'd2, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32,
                       1'b1, 1'b0, 1'b0));
      // only the second bandwidth kind over its limit
      add_row(word_row(2'd3, '0, MAX32, '0, MAX32, '0, MAX32, 1'b1, 1'b1, 1'b0));
      // only the first kind over its limit
      add_row(word_row(2'd3, MAX32, '0, MAX32, '0, MAX32, MAX32));
      // fill node 2's window with full-scale samples
      repeat (4) begin
         add_row(word_row(2'd2, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32));
      end
      add_row(reg_row(CSR_WINDOW_LENGTH, 7'd1));
      add_row(word_row(2'd0, 32'd1000, '0, 32'd1000, 32'd1000, MAX32, 32'd1000));
      add_row(reg_row(CSR_BANDWIDTH_PERCENT, 7'd100));
      add_row(reg_row(CSR_CAPACITY_PERCENT, 7'd100));
      // average equal to the limit does not flag, one above does
      add_row(word_row(2'd0, 32'd1000, '0, 32'd1000, 32'd1000, MAX32, 32'd1000));
      add_row(word_row(2'd0, 32'd1001, '0, 32'd1001, 32'd1000, MAX32, 32'd1000));
      // percent above hundred and zero percent
      add_row(reg_row(CSR_BANDWIDTH_PERCENT, 7'd127));
      add_row(reg_row(CSR_CAPACITY_PERCENT, 7'd0));
      add_row(word_row(2'd1, 32'd1270, 32'd1271, 32'd1, 32'd1000, 32'd1000, MAX32));
      // window zero acts as one
      add_row(reg_row(CSR_WINDOW_LENGTH, 7'd0));
      add_row(word_row(2'd1, 32'd5, 32'd7, '0, 32'd4, 32'd9, '0));
      // window above history depth is clamped, then exactly the depth
      add_row(reg_row(CSR_WINDOW_LENGTH, 7'd127));
      add_row(word_row(2'd3, MAX32, 32'd12345, MAX32, MAX32, 32'd100, MAX32));
      add_row(reg_row(CSR_WINDOW_LENGTH, 7'd64));
      add_row(word_row(2'd2, '0, '0, '0, MAX32, MAX32, 32'd1));

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[r]) begin
         if (directed[r].kind == ROW_REG) begin
            wait_drained();
            write_reg(directed[r].reg_index, directed[r].reg_value);
         end else begin
            offer_word(directed[r].word, directed[r].typed, directed[r].flags);
         end
      end

      // random phases, each with its own settings, ceilings and pacing
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase % 6)
            0: write_reg(CSR_WINDOW_LENGTH, 7'd1);
            1: write_reg(CSR_WINDOW_LENGTH, REG_W'($urandom_range(12, 2)));
            2: write_reg(CSR_WINDOW_LENGTH, 7'd64);
            3: write_reg(CSR_WINDOW_LENGTH, 7'd127);
            4: write_reg(CSR_WINDOW_LENGTH, 7'd0);
            default: write_reg(CSR_WINDOW_LENGTH, REG_W'($urandom_range(63, 2)));
         endcase
         write_reg(CSR_BANDWIDTH_PERCENT, pick_percent(phase));
         write_reg(CSR_CAPACITY_PERCENT, pick_percent(phase + 2));

         for (int n = 0; n < NODE_COUNT; n++) begin
            node_ceil_a[n]   = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : $urandom;
            node_ceil_b[n]   = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : $urandom;
            node_ceil_cap[n] = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : $urandom;
         end

         pace = pace_type'(phase % 4);
         case (pace)
            PACE_SENDER: begin
               send_idle_pct = SENDER_IDLE_PCT;
               stall_pct     = 0;
            end
            PACE_RECEIVER: begin
               send_idle_pct = 0;
               stall_pct     = RECEIVER_STALL_PCT;
            end
            PACE_BOTH: begin
               send_idle_pct = BOTH_IDLE_PCT;
               stall_pct     = BOTH_IDLE_PCT;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
         endcase

         // long output hold-off while samples keep coming, so the block backs up
         hold_phase = (phase % 6 == 3);
         if (hold_phase) begin
            hold_requests++;
         end

         for (int i = 0; i < PHASE_WORDS; i++) begin
            // halfway through a hold phase, let everything drain before going on
            if (hold_phase && i == PHASE_WORDS / 2) begin
               wait_drained();
            end
            while ($urandom_range(99) < send_idle_pct) begin
               req_ch.valid <= 1'b0;
               @(negedge clock);
            end

            // runs on one node now and then, so windows fill with related samples
            sample.node = ($urandom_range(1) == 0) ? last_node : NODE_W'($urandom_range(3));
            last_node   = sample.node;
            mix = $urandom_range(15);
            if (mix == 0) begin
               sample.bandwidth_a         = $urandom;
               sample.bandwidth_b         = $urandom;
               sample.capacity_used       = $urandom;
               sample.ceiling_bandwidth_a = $urandom;
               sample.ceiling_bandwidth_b = $urandom;
               sample.ceiling_capacity    = $urandom;
            end else if (mix == 1) begin
               sample.bandwidth_a         = pick_extreme();
               sample.bandwidth_b         = pick_extreme();
               sample.capacity_used       = pick_extreme();
               sample.ceiling_bandwidth_a = pick_extreme();
               sample.ceiling_bandwidth_b = pick_extreme();
               sample.ceiling_capacity    = pick_extreme();
            end else begin
               // realistic monitoring: fixed node ceilings, readings near the limit
               sample.ceiling_bandwidth_a = node_ceil_a[sample.node];
               sample.ceiling_bandwidth_b = node_ceil_b[sample.node];
               sample.ceiling_capacity    = node_ceil_cap[sample.node];
               sample.bandwidth_a   = near_limit(sample.ceiling_bandwidth_a, bw_percent_reg);
               sample.bandwidth_b   = near_limit(sample.ceiling_bandwidth_b, bw_percent_reg);
               sample.capacity_used = near_limit(sample.ceiling_capacity, cap_percent_reg);
            end
            offer_word(sample, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/wsd_pkg.sv
rtl/core/wsd_channels.sv
rtl/core/wsd_history_mem.sv
rtl/core/wsd_threshold.sv
rtl/core/wsd_walker.sv
rtl/core/windowed_saturation_detector.sv
rtl/core/wsd_checker.sv
verif/windowed_saturation_detector_tb.sv
